// ===== src/drt_pkg.sv =====
// shared types, codes and constants of the divider and reload timer
// no dependencies; imported by every other file of the block
`default_nettype none

package drt_pkg;

  // ticks per divider step
  localparam int unsigned DIV_TICKS  = 256;
  localparam int unsigned PRESCALE_W = $clog2(DIV_TICKS);

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned PERIOD_W = 11;

  // control register fields
  localparam int unsigned CTRL_ENABLE_BIT = 2;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    REG_DIV     = 2'd0,
    REG_COUNT   = 2'd1,
    REG_MODULO  = 2'd2,
    REG_CONTROL = 2'd3
  } reg_addr_t;

  typedef enum logic [1:0] {
    SEL_1024 = 2'd0,
    SEL_16   = 2'd1,
    SEL_64   = 2'd2,
    SEL_256  = 2'd3
  } period_sel_t;

  typedef struct packed {
    cmd_t              cmd;
    reg_addr_t         reg_addr;
    logic [BYTE_W-1:0] write_byte;
  } item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] read_byte;
    logic              timer_irq;
  } result_t;

  localparam logic [PERIOD_W-1:0] RESET_PERIOD = PERIOD_W'(1024);

  function automatic logic [PERIOD_W-1:0] period_for(input logic [1:0] sel);
    logic [PERIOD_W-1:0] p;
    unique case (period_sel_t'(sel))
      SEL_1024: p = PERIOD_W'(1024);
      SEL_16:   p = PERIOD_W'(16);
      SEL_64:   p = PERIOD_W'(64);
      SEL_256:  p = PERIOD_W'(256);
      default:  p = PERIOD_W'(1024);
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

// ===== src/drt_if.sv =====
// valid/ready channel interfaces for the request and response sides
// depends on drt_pkg for the byte width
`default_nettype none

interface drt_req_if
  import drt_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [1:0]        cmd;
  logic [1:0]        reg_addr;
  logic [BYTE_W-1:0] write_byte;

  modport source (output valid, output cmd, output reg_addr, output write_byte,
                  input ready);
  modport sink   (input valid, input cmd, input reg_addr, input write_byte,
                  output ready);
endinterface

interface drt_rsp_if
  import drt_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] read_byte;
  logic              timer_irq;

  modport source (output valid, output read_byte, output timer_irq, input ready);
  modport sink   (input valid, input read_byte, input timer_irq, output ready);
endinterface

`default_nettype wire

// ===== src/divider_and_reload_timer_top.sv =====
// divider and reload timer: input register, timer core and result register
// depends on drt_pkg, drt_if (drt_req_if, drt_rsp_if) and drt_core
//
// Emulated handheld timer with divider, counter, modulo and control byte
// registers. Every request is a clock tick, a register read or a register
// write, and gives exactly one response carrying read_byte (the register on
// a read, zero otherwise) and timer_irq (set when a tick overflowed the
// enabled counter, which then reloads from modulo). Throughput is one request
// per clock cycle while the response side does not stall. A request passes
// through the input register, then through the timer core into the result
// register, before its response is offered. The request side keeps accepting
// while a response waits, as long as the input register is empty, so a
// stalled response backs up at most two items.
`default_nettype none

module divider_and_reload_timer_top
  import drt_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  drt_req_if.sink    req,
  drt_rsp_if.source  rsp
);

  // input register
  logic    in_valid;
  item_t   in_item;
  // result register
  logic    out_valid;
  result_t out_result;

  result_t core_result;
  logic    advance;
  logic    req_xfer;

  // the input register empties into the result register when that is free
  // or being drained in this cycle
  assign advance  = in_valid && (!out_valid || rsp.ready);
  assign req.ready = !in_valid || advance;
  assign req_xfer = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req_xfer) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (req_xfer) begin
      in_item.cmd        <= cmd_t'(req.cmd);
      in_item.reg_addr   <= reg_addr_t'(req.reg_addr);
      in_item.write_byte <= req.write_byte;
    end
  end

  // timer state commits exactly when its item moves to the result register
  drt_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .item   (in_item),
    .result (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= core_result;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.read_byte = out_result.read_byte;
  assign rsp.timer_irq = out_result.timer_irq;

endmodule

`default_nettype wire

// ===== src/drt_core.sv =====
// timer register file and single-pass update logic for one item
// depends on drt_pkg
`default_nettype none

module drt_core
  import drt_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    fire,
  input  wire item_t   item,
  output result_t      result
);

  logic [BYTE_W-1:0]     div_value, div_value_next;
  logic [PRESCALE_W-1:0] div_prescale, div_prescale_next;
  logic [BYTE_W-1:0]     count_value, count_value_next;
  logic [BYTE_W-1:0]     modulo_value, modulo_value_next;
  logic [BYTE_W-1:0]     control_value, control_value_next;
  logic [PERIOD_W-1:0]   latched_period, latched_period_next;
  logic [PERIOD_W-1:0]   period_countdown, period_countdown_next;
  logic [BYTE_W:0]       count_inc;

  always_comb begin
    div_value_next        = div_value;
    div_prescale_next     = div_prescale;
    count_value_next      = count_value;
    modulo_value_next     = modulo_value;
    control_value_next    = control_value;
    latched_period_next   = latched_period;
    period_countdown_next = period_countdown;
    result                = '0;
    count_inc             = {1'b0, count_value} + (BYTE_W+1)'(1);

    unique case (item.cmd)
      CMD_TICK: begin
        if (div_prescale == PRESCALE_W'(DIV_TICKS - 1)) begin
          div_prescale_next = '0;
          div_value_next    = div_value + BYTE_W'(1);
        end else begin
          div_prescale_next = div_prescale + PRESCALE_W'(1);
        end
        // expiry at one or zero
        if (period_countdown <= PERIOD_W'(1)) begin
          period_countdown_next = latched_period;
          if (control_value[CTRL_ENABLE_BIT]) begin
            if (count_inc[BYTE_W]) begin
              count_value_next = modulo_value;
              result.timer_irq = 1'b1;
            end else begin
              count_value_next = count_inc[BYTE_W-1:0];
            end
          end
        end else begin
          period_countdown_next = period_countdown - PERIOD_W'(1);
        end
      end
      CMD_READ: begin
        unique case (item.reg_addr)
          REG_DIV:     result.read_byte = div_value;
          REG_COUNT:   result.read_byte = count_value;
          REG_MODULO:  result.read_byte = modulo_value;
          REG_CONTROL: result.read_byte = control_value;
          default:     result.read_byte = '0;
        endcase
      end
      CMD_WRITE: begin
        unique case (item.reg_addr)
          REG_DIV:     div_value_next    = '0;
          REG_COUNT:   count_value_next  = item.write_byte;
          REG_MODULO:  modulo_value_next = item.write_byte;
          REG_CONTROL: begin
            control_value_next  = item.write_byte;
            latched_period_next = period_for(item.write_byte[1:0]);
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_value        <= '0;
      div_prescale     <= '0;
      count_value      <= '0;
      modulo_value     <= '0;
      control_value    <= '0;
      latched_period   <= RESET_PERIOD;
      period_countdown <= RESET_PERIOD;
    end else if (fire) begin
      div_value        <= div_value_next;
      div_prescale     <= div_prescale_next;
      count_value      <= count_value_next;
      modulo_value     <= modulo_value_next;
      control_value    <= control_value_next;
      latched_period   <= latched_period_next;
      period_countdown <= period_countdown_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/drt_checker.sv =====
// port-level checks of the divider and reload timer and their bind
// depends on drt_pkg; binds into divider_and_reload_timer_top
`default_nettype none

module drt_checker
  import drt_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              req_valid,
  input wire logic              req_ready,
  input wire logic              rsp_valid,
  input wire logic              rsp_ready,
  input wire logic [BYTE_W-1:0] read_byte,
  input wire logic              timer_irq
);

  // requests taken whose responses are not yet delivered
  logic [1:0] pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 2'((req_valid && req_ready) ? 1 : 0)
                         - 2'((rsp_valid && rsp_ready) ? 1 : 0);
    end
  end

  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending != 2'd3)
    else $error("more than two requests in flight");

  a_no_invented_rsp: assert property (@(posedge clk) disable iff (rst)
    pending == 2'd0 |-> !rsp_valid)
    else $error("response without an outstanding request");

  a_irq_zero_data: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && timer_irq |-> read_byte == '0)
    else $error("interrupt response carries read data");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(read_byte) && $stable(timer_irq))
    else $error("stalled response changed");

endmodule

bind divider_and_reload_timer_top drt_checker u_drt_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .read_byte (rsp.read_byte),
  .timer_irq (rsp.timer_irq)
);

`default_nettype wire
